### design/fat16_cluster_chain_manager_unit_defines.svh
// Assertion macros shared by the cluster table controller and datapath.
// No dependencies; included by files that carry concurrent assertions.
`ifndef FAT16_CLUSTER_CHAIN_MANAGER_UNIT_DEFINES_SVH
`define FAT16_CLUSTER_CHAIN_MANAGER_UNIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define FCM_ASSERT_NOW(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("fcm assertion failed");

// next-cycle implication, disabled in reset
`define FCM_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("fcm assertion failed");

`endif

### design/fcm_pkg.sv
// Types, codes and sizes for the FAT16 cluster table unit.
// No dependencies; imported by fcm_ctrl, fcm_dp and the top level.
package fcm_pkg;

    localparam int NUM_CLUSTERS = 4096;
    localparam int IDX_W        = $clog2(NUM_CLUSTERS);
    localparam int CNT_W        = IDX_W + 1;

    localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;
    localparam logic [15:0] CHAIN_TOP    = 16'hFFF0;
    localparam logic [15:0] FIRST_DATA   = 16'h0002;
    localparam logic [15:0] FREE_MARK    = 16'h0000;

    localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(NUM_CLUSTERS);

    localparam logic [1:0] MODE_LOAD  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_ALLOC = 2'd2;
    localparam logic [1:0] MODE_FREE  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_LOOP  = 2'd3;

    localparam logic [1:0] RES_NONE  = 2'd0;
    localparam logic [1:0] RES_RDATA = 2'd1;
    localparam logic [1:0] RES_FOUND = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] cluster;
        logic [15:0] entry_value;
        logic        link_tail;
    } fcm_req_t;

    typedef struct packed {
        logic [15:0]      result_value;
        logic [CNT_W-1:0] freed_count;
        logic [1:0]       status;
    } fcm_rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic       capture;
        logic       load_wr;
        logic       rd_cl;
        logic       cur_init;
        logic       fr_issue;
        logic       fr_step;
        logic       al_init;
        logic       al_step;
        logic       al_link;
        logic       al_mark;
        logic       done;
        logic [1:0] st;
        logic [1:0] res_sel;
    } fcm_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] mode;
        logic       link;
        logic       cl_ok;
        logic       tail_ok;
        logic       cur_chain;
        logic       cur_ok;
        logic       cnt_full;
        logic       hit;
        logic       scan_more;
        logic       chk_valid;
    } fcm_stat_t;

endpackage

### design/fcm_dp.sv
// Datapath of the cluster table unit: table memory, walk and scan registers.
// Depends on fcm_pkg and the assertion macro header.
`include "fat16_cluster_chain_manager_unit_defines.svh"

module fcm_dp
    import fcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fcm_req_t         req,
    input  logic             cfg_valid,
    input  logic [CNT_W-1:0] cfg_data,
    input  fcm_cmd_t         cmd,
    output fcm_stat_t        stat,
    output logic             done,
    output fcm_rsp_t         rsp
);

    logic [15:0]      mem [NUM_CLUSTERS];

    logic [CNT_W-1:0] limit_reg;
    logic             res_valid_reg;
    logic             chk_valid_reg, chk_valid_next;
    fcm_req_t         req_reg;
    fcm_rsp_t         rsp_reg;
    logic [15:0]      cur_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] scan_reg;
    logic [IDX_W-1:0] chk_reg;
    logic [IDX_W-1:0] found_reg;
    logic [15:0]      rdata_reg;

    logic [CNT_W-1:0] lim;
    logic [15:0]      lim16;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [15:0]      wr_data;
    logic             issue;

    assign lim   = (limit_reg > LIMIT_MAX) ? LIMIT_MAX : limit_reg;
    assign lim16 = 16'(lim);
    assign issue = cmd.al_step && !stat.hit && (scan_reg < lim);

    always_comb
    begin
        stat.mode      = req_reg.mode;
        stat.link      = req_reg.link_tail;
        stat.cl_ok     = req_reg.cluster < lim16;
        stat.tail_ok   = (req_reg.cluster >= FIRST_DATA) && (req_reg.cluster < lim16);
        stat.cur_chain = (cur_reg >= FIRST_DATA) && (cur_reg < CHAIN_TOP);
        stat.cur_ok    = cur_reg < lim16;
        stat.cnt_full  = cnt_reg >= lim;
        stat.hit       = chk_valid_reg && (rdata_reg == FREE_MARK);
        stat.scan_more = scan_reg < lim;
        stat.chk_valid = chk_valid_reg;
    end

    // read port select
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = req_reg.cluster[IDX_W-1:0];
        if (cmd.rd_cl)
        begin
            rd_en = 1'b1;
        end
        else if (cmd.fr_issue)
        begin
            rd_en   = 1'b1;
            rd_addr = cur_reg[IDX_W-1:0];
        end
        else if (issue)
        begin
            rd_en   = 1'b1;
            rd_addr = scan_reg[IDX_W-1:0];
        end
    end

    // write port select
    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = req_reg.cluster[IDX_W-1:0];
        wr_data = req_reg.entry_value;
        if (cmd.load_wr)
        begin
            wr_data = req_reg.entry_value;
        end
        else if (cmd.fr_step)
        begin
            wr_addr = cur_reg[IDX_W-1:0];
            wr_data = FREE_MARK;
        end
        else if (cmd.al_link)
        begin
            wr_data = 16'(found_reg);
        end
        else if (cmd.al_mark)
        begin
            wr_addr = found_reg;
            wr_data = END_OF_CHAIN;
        end
        else
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        chk_valid_next = chk_valid_reg;
        if (cmd.al_init)
        begin
            chk_valid_next = 1'b0;
        end
        else if (cmd.al_step)
        begin
            chk_valid_next = issue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg     <= LIMIT_MAX;
            res_valid_reg <= 1'b0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            res_valid_reg <= cmd.done;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (cmd.cur_init)
        begin
            cur_reg <= req_reg.cluster;
            cnt_reg <= '0;
        end
        else if (cmd.fr_step)
        begin
            cur_reg <= rdata_reg;
            cnt_reg <= cnt_reg + 1'b1;
        end
        if (cmd.al_init)
        begin
            scan_reg <= CNT_W'(FIRST_DATA);
        end
        else if (issue)
        begin
            scan_reg <= scan_reg + 1'b1;
            chk_reg  <= scan_reg[IDX_W-1:0];
        end
        if (cmd.al_step && stat.hit)
        begin
            found_reg <= chk_reg;
        end
        if (cmd.done)
        begin
            rsp_reg.status      <= cmd.st;
            rsp_reg.freed_count <= (req_reg.mode == MODE_FREE) ? cnt_reg : '0;
            case (cmd.res_sel)
                RES_RDATA: rsp_reg.result_value <= rdata_reg;
                RES_FOUND: rsp_reg.result_value <= 16'(found_reg);
                default:   rsp_reg.result_value <= '0;
            endcase
        end
    end

    assign done = res_valid_reg;
    assign rsp  = rsp_reg;

    `FCM_ASSERT_NEXT(a_strobe_single, clk, rst_n, res_valid_reg, !res_valid_reg)
    `FCM_ASSERT_NEXT(a_free_counts, clk, rst_n, cmd.fr_step, cnt_reg == $past(cnt_reg) + 1'b1)
    `FCM_ASSERT_NOW(a_loop_at_limit, clk, rst_n, res_valid_reg && (rsp_reg.status == ST_LOOP),
        rsp_reg.freed_count == lim)

endmodule

### design/fcm_ctrl.sv
// Sequencer of the cluster table unit: dispatches an operation and steps it.
// Depends on fcm_pkg and the assertion macro header.
`include "fat16_cluster_chain_manager_unit_defines.svh"

module fcm_ctrl
    import fcm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  fcm_stat_t stat,
    output fcm_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_DISP    = 3'd1;
    localparam logic [2:0] S_RD_WAIT = 3'd2;
    localparam logic [2:0] S_FR_CHK  = 3'd3;
    localparam logic [2:0] S_FR_DATA = 3'd4;
    localparam logic [2:0] S_AL_SCAN = 3'd5;
    localparam logic [2:0] S_AL_LINK = 3'd6;
    localparam logic [2:0] S_AL_MARK = 3'd7;

    logic [2:0] state_reg, state_next;

    assign busy = state_reg != S_IDLE;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DISP;
                end
            end
            S_DISP:
            begin
                case (stat.mode)
                    MODE_LOAD:
                    begin
                        cmd.load_wr = stat.cl_ok;
                        cmd.done    = 1'b1;
                        cmd.st      = stat.cl_ok ? ST_OK : ST_RANGE;
                        state_next  = S_IDLE;
                    end
                    MODE_READ:
                    begin
                        if (stat.cl_ok)
                        begin
                            cmd.rd_cl  = 1'b1;
                            state_next = S_RD_WAIT;
                        end
                        else
                        begin
                            cmd.done   = 1'b1;
                            cmd.st     = ST_RANGE;
                            state_next = S_IDLE;
                        end
                    end
                    MODE_ALLOC:
                    begin
                        if (stat.link && !stat.tail_ok)
                        begin
                            cmd.done   = 1'b1;
                            cmd.st     = ST_RANGE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd.al_init = 1'b1;
                            state_next  = S_AL_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.cur_init = 1'b1;
                        state_next   = S_FR_CHK;
                    end
                endcase
            end
            S_RD_WAIT:
            begin
                cmd.done    = 1'b1;
                cmd.st      = ST_OK;
                cmd.res_sel = RES_RDATA;
                state_next  = S_IDLE;
            end
            S_FR_CHK:
            begin
                if (!stat.cur_chain)
                begin
                    cmd.done   = 1'b1;
                    cmd.st     = ST_OK;
                    state_next = S_IDLE;
                end
                else if (!stat.cur_ok)
                begin
                    cmd.done   = 1'b1;
                    cmd.st     = ST_RANGE;
                    state_next = S_IDLE;
                end
                else if (stat.cnt_full)
                begin
                    cmd.done   = 1'b1;
                    cmd.st     = ST_LOOP;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.fr_issue = 1'b1;
                    state_next   = S_FR_DATA;
                end
            end
            S_FR_DATA:
            begin
                cmd.fr_step = 1'b1;
                state_next  = S_FR_CHK;
            end
            S_AL_SCAN:
            begin
                cmd.al_step = 1'b1;
                if (stat.hit)
                begin
                    state_next = stat.link ? S_AL_LINK : S_AL_MARK;
                end
                else if (!stat.scan_more && !stat.chk_valid)
                begin
                    cmd.done   = 1'b1;
                    cmd.st     = ST_FULL;
                    state_next = S_IDLE;
                end
            end
            S_AL_LINK:
            begin
                cmd.al_link = 1'b1;
                state_next  = S_AL_MARK;
            end
            S_AL_MARK:
            begin
                cmd.al_mark = 1'b1;
                cmd.done    = 1'b1;
                cmd.st      = ST_OK;
                cmd.res_sel = RES_FOUND;
                state_next  = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `FCM_ASSERT_NEXT(a_start_dispatch, clk, rst_n, (state_reg == S_IDLE) && start,
        state_reg == S_DISP)
    `FCM_ASSERT_NEXT(a_done_to_idle, clk, rst_n, cmd.done, state_reg == S_IDLE)
    `FCM_ASSERT_NEXT(a_issue_then_step, clk, rst_n, cmd.fr_issue, cmd.fr_step)

endmodule

### design/fat16_cluster_chain_manager_unit.sv
// Top level of the FAT16 cluster table unit: sequencer plus datapath.
// Depends on fcm_pkg, fcm_ctrl and fcm_dp.
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  request  | start, busy, req               | word taken when start & !busy
//  result   | done, rsp                      | one-cycle strobe, no back-pressure
//  config   | cfg_valid, cfg_ready, cfg_data | written when cfg_valid & cfg_ready
//
// Load writes in dispatch; read reads there and answers from the wait state;
// allocate scans from slot 2, links the tail if asked, marks the slot; free
// takes check and data states per cluster; a read or allocate refused on range
// answers in dispatch. The single read port (one per cycle) paces scan and walk.
// Reset clears the sequencer and sets the limit to 4096; the table is not
// cleared and must be loaded. Configuration is always ready.
module fat16_cluster_chain_manager_unit
    import fcm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fcm_req_t         req,
    output logic             done,
    output fcm_rsp_t         rsp,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

    fcm_cmd_t  cmd;
    fcm_stat_t stat;

    assign cfg_ready = 1'b1;

    fcm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    fcm_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .rsp       (rsp)
    );

endmodule

### verif/tb_top.sv
// Self-checking bench for the FAT16 cluster table unit: directed cases, then random
// phases over several table limits, each word checked against an in-bench table model.
// Depends on fcm_pkg and fat16_cluster_chain_manager_unit.
module tb_top;
    import fcm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WD_LIMIT = 40000;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             start;
    logic             busy;
    fcm_req_t         req;
    logic             done;
    fcm_rsp_t         rsp;
    logic             cfg_valid;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data;

    // table image, which entries have been written, and the limit register
    logic [15:0]      fat_img [NUM_CLUSTERS];
    bit               fat_known [NUM_CLUSTERS];
    logic [CNT_W-1:0] lim_cfg;

    fcm_rsp_t rsp_due [$];
    fcm_rsp_t rsp_head;
    int       file_heads [$];
    int       file_tail;
    int       burst_left;
    int       idle_cycles;
    int       errors;
    int       words_sent;
    int       cfg_writes;
    int       alloc_ok;
    int       full_seen;
    int       range_seen;
    int       freed_total;

    always #5 clk = ~clk;

    fat16_cluster_chain_manager_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    function automatic int unsigned eff_lim();
        return (lim_cfg < NUM_CLUSTERS) ? int'(lim_cfg) : NUM_CLUSTERS;
    endfunction

    function automatic fcm_req_t mk(input logic [1:0] m, input logic [15:0] c,
                                    input logic [15:0] v, input logic l);
        fcm_req_t w;
        w.mode        = m;
        w.cluster     = c;
        w.entry_value = v;
        w.link_tail   = l;
        return w;
    endfunction

    // Applies one word to the table image and returns the result it must give.
    function automatic fcm_rsp_t fat_apply(input fcm_req_t w);
        fcm_rsp_t    r;
        int unsigned lim;
        int unsigned cur;
        int unsigned nxt;
        int unsigned cnt;
        int unsigned slot;
        bit          found;
        lim   = eff_lim();
        r     = '0;
        cnt   = 0;
        slot  = 0;
        found = 1'b0;
        case (w.mode)
            MODE_LOAD:
            begin
                if (w.cluster < lim)
                begin
                    fat_img[w.cluster]   = w.entry_value;
                    fat_known[w.cluster] = 1'b1;
                end
                else
                    r.status = ST_RANGE;
            end
            MODE_READ:
            begin
                if (w.cluster < lim)
                    r.result_value = fat_img[w.cluster];
                else
                    r.status = ST_RANGE;
            end
            MODE_ALLOC:
            begin
                if (w.link_tail && (w.cluster < FIRST_DATA || w.cluster >= lim))
                    r.status = ST_RANGE;
                else
                begin
                    for (int i = FIRST_DATA; i < lim && !found; i++)
                    begin
                        if (fat_img[i] == FREE_MARK)
                        begin
                            found = 1'b1;
                            slot  = i;
                        end
                    end
                    if (!found)
                        r.status = ST_FULL;
                    else
                    begin
                        // link first, end mark second: a self-linked tail ends as end of chain
                        if (w.link_tail)
                        begin
                            fat_img[w.cluster]   = 16'(slot);
                            fat_known[w.cluster] = 1'b1;
                        end
                        fat_img[slot]   = END_OF_CHAIN;
                        fat_known[slot] = 1'b1;
                        r.result_value  = 16'(slot);
                    end
                end
            end
            default:
            begin
                cur = w.cluster;
                while (cur >= FIRST_DATA && cur < CHAIN_TOP)
                begin
                    if (cur >= lim)
                    begin
                        r.status = ST_RANGE;
                        break;
                    end
                    if (cnt >= lim)
                    begin
                        r.status = ST_LOOP;
                        break;
                    end
                    nxt            = fat_img[cur];
                    fat_img[cur]   = FREE_MARK;
                    fat_known[cur] = 1'b1;
                    cnt++;
                    cur = nxt;
                end
                r.freed_count = CNT_W'(cnt);
            end
        endcase
        return r;
    endfunction

    // First table entry the word would read before it was ever written, else -1.
    function automatic int first_blind_read(input fcm_req_t w);
        int unsigned lim;
        int unsigned cur;
        int unsigned cnt;
        bit          seen [int unsigned];
        lim = eff_lim();
        case (w.mode)
            MODE_LOAD:
                return -1;
            MODE_READ:
                return (w.cluster < lim && !fat_known[w.cluster]) ? int'(w.cluster) : -1;
            MODE_ALLOC:
            begin
                if (w.link_tail && (w.cluster < FIRST_DATA || w.cluster >= lim))
                    return -1;
                for (int i = FIRST_DATA; i < lim; i++)
                begin
                    if (!fat_known[i])
                        return i;
                    if (fat_img[i] == FREE_MARK)
                        return -1;
                end
                return -1;
            end
            default:
            begin
                cur = w.cluster;
                cnt = 0;
                while (cur >= FIRST_DATA && cur < CHAIN_TOP)
                begin
                    if (cur >= lim || cnt >= lim)
                        return -1;
                    if (seen.exists(cur))
                        cur = 0;
                    else
                    begin
                        if (!fat_known[cur])
                            return int'(cur);
                        seen[cur] = 1'b1;
                        cur       = fat_img[cur];
                    end
                    cnt++;
                end
                return -1;
            end
        endcase
    endfunction

    // Called at a rising edge; returns when the word is taken, or after an idle gap.
    task automatic push_word(input fcm_req_t w, output fcm_rsp_t due);
        start <= 1'b1;
        req   <= w;
        do
            @(posedge clk);
        while (busy);
        due = fat_apply(w);
        rsp_due.push_back(due);
        words_sent++;
        if (w.mode == MODE_ALLOC && due.status == ST_OK)
            alloc_ok++;
        if (due.status == ST_FULL)
            full_seen++;
        if (due.status == ST_RANGE)
            range_seen++;
        freed_total += int'(due.freed_count);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                                      : $urandom_range(0, 8);
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    // Loads any entry the word would read blind, then sends the word itself.
    task automatic issue(input fcm_req_t w, output fcm_rsp_t due);
        fcm_req_t fill;
        int       blind;
        blind = first_blind_read(w);
        while (blind >= 0)
        begin
            fill = mk(MODE_LOAD, 16'(blind), $urandom_range(0, 1) ? FREE_MARK : 16'($urandom),
                      1'b0);
            push_word(fill, due);
            blind = first_blind_read(w);
        end
        push_word(w, due);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        burst_left = 0;
        while (rsp_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input int unsigned v);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= CNT_W'(v);
        do
            @(posedge clk);
        while (!cfg_ready);
        lim_cfg = CNT_W'(v);
        cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    task automatic run_random(input int n);
        fcm_req_t    w;
        fcm_rsp_t    due;
        int unsigned lim;
        int          pick;
        int          k;
        file_tail = -1;
        file_heads.delete();
        for (int i = 0; i < n; i++)
        begin
            lim  = eff_lim();
            pick = $urandom_range(0, 99);
            w    = mk(MODE_READ, 16'($urandom), 16'($urandom), 1'($urandom));
            if (pick < 30)
            begin
                // grow the current file or start a new one
                w.mode      = MODE_ALLOC;
                w.link_tail = (file_tail >= 0) && ($urandom_range(0, 4) != 0);
                if (w.link_tail)
                    w.cluster = 16'(file_tail);
            end
            else if (pick < 45)
            begin
                w.mode = MODE_FREE;
                if (file_heads.size() != 0 && $urandom_range(0, 4) != 0)
                begin
                    k         = $urandom_range(0, file_heads.size() - 1);
                    w.cluster = 16'(file_heads[k]);
                    if (k == file_heads.size() - 1)
                        file_tail = -1;
                    file_heads.delete(k);
                end
                else if ($urandom_range(0, 3) != 0)
                    w.cluster = 16'($urandom_range(0, lim + 3));
            end
            else if (pick < 65)
            begin
                if ($urandom_range(0, 9) != 0)
                    w.cluster = 16'($urandom_range(0, lim - 1));
            end
            else if (pick < 90)
            begin
                w.mode = MODE_LOAD;
                if ($urandom_range(0, 9) != 0)
                    w.cluster = 16'($urandom_range(0, lim - 1));
                case ($urandom_range(0, 5))
                    0: w.entry_value = FREE_MARK;
                    1: w.entry_value = 16'($urandom_range(0, lim - 1));
                    2: w.entry_value = END_OF_CHAIN;
                    3: ;
                    4: w.entry_value = 16'($urandom_range(16'hFFEE, 16'hFFF1));
                    default: w.entry_value = 16'($urandom_range(FIRST_DATA, 16'hFFEF));
                endcase
            end
            else
                w.mode = 2'($urandom);
            issue(w, due);
            if (w.mode == MODE_ALLOC && due.status == ST_OK)
            begin
                file_tail = due.result_value;
                if (!w.link_tail)
                begin
                    file_heads.push_back(file_tail);
                    if (file_heads.size() > 32)
                        void'(file_heads.pop_front());
                end
            end
            if ($urandom_range(0, 199) == 0)
                drain_results();
        end
    endtask

    task automatic test_directed();
        fcm_rsp_t due;
        issue(mk(MODE_LOAD, 16'd0, END_OF_CHAIN, 1'b0), due);
        issue(mk(MODE_LOAD, 16'd4095, FREE_MARK, 1'b1), due);
        issue(mk(MODE_LOAD, 16'd4096, 16'h1234, 1'b0), due);
        issue(mk(MODE_LOAD, 16'hFFFF, 16'hFFFF, 1'b0), due);
        issue(mk(MODE_READ, 16'd0, 16'd0, 1'b0), due);
        issue(mk(MODE_READ, 16'd4095, 16'd0, 1'b0), due);
        issue(mk(MODE_READ, 16'd4096, 16'd0, 1'b0), due);
        issue(mk(MODE_LOAD, 16'd2, FREE_MARK, 1'b0), due);
        issue(mk(MODE_LOAD, 16'd3, FREE_MARK, 1'b0), due);
        issue(mk(MODE_LOAD, 16'd4, FREE_MARK, 1'b0), due);
        issue(mk(MODE_ALLOC, 16'd0, 16'd0, 1'b0), due);
        issue(mk(MODE_ALLOC, 16'd2, 16'd0, 1'b1), due);
        issue(mk(MODE_ALLOC, 16'd1, 16'd0, 1'b1), due);
        issue(mk(MODE_ALLOC, 16'd4096, 16'd0, 1'b1), due);
        // tail is the slot about to be taken
        issue(mk(MODE_ALLOC, 16'd4, 16'd0, 1'b1), due);
        issue(mk(MODE_READ, 16'd2, 16'd0, 1'b0), due);
        issue(mk(MODE_FREE, 16'd2, 16'd0, 1'b0), due);
        issue(mk(MODE_FREE, 16'd0, 16'd0, 1'b0), due);
        issue(mk(MODE_FREE, CHAIN_TOP, 16'd0, 1'b0), due);
        issue(mk(MODE_FREE, 16'hFFFF, 16'd0, 1'b0), due);
        // chain running off the table
        issue(mk(MODE_LOAD, 16'd5, 16'hFFEF, 1'b0), due);
        issue(mk(MODE_FREE, 16'd5, 16'd0, 1'b0), due);
        // two-entry loop
        issue(mk(MODE_LOAD, 16'd6, 16'd7, 1'b0), due);
        issue(mk(MODE_LOAD, 16'd7, 16'd6, 1'b0), due);
        issue(mk(MODE_FREE, 16'd6, 16'd0, 1'b0), due);
    endtask

    task automatic test_limit_floor();
        fcm_rsp_t due;
        write_limit(2);
        issue(mk(MODE_ALLOC, 16'd0, 16'd0, 1'b0), due);
        issue(mk(MODE_ALLOC, 16'd1, 16'd0, 1'b1), due);
        issue(mk(MODE_READ, 16'd1, 16'd0, 1'b0), due);
        issue(mk(MODE_LOAD, 16'd2, 16'hFFFF, 1'b0), due);
        issue(mk(MODE_FREE, 16'd2, 16'd0, 1'b0), due);
        issue(mk(MODE_READ, 16'd0, 16'd0, 1'b0), due);
    endtask

    task automatic test_small_table();
        write_limit(8);
        run_random(300);
    endtask

    task automatic test_single_slot();
        write_limit(3);
        run_random(150);
    endtask

    task automatic test_mid_table();
        write_limit($urandom_range(9, 64));
        run_random(350);
    endtask

    task automatic test_wide_table();
        write_limit($urandom_range(65, 600));
        run_random(350);
    endtask

    task automatic test_full_table();
        write_limit(NUM_CLUSTERS);
        run_random(450);
    endtask

    task automatic test_any_limit();
        write_limit($urandom_range(2, NUM_CLUSTERS));
        run_random(150);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (rsp_due.size() == 0)
            begin
                $display("%0t: result word %h with nothing expected", $time, rsp);
                errors++;
            end
            else
            begin
                rsp_head = rsp_due.pop_front();
                if (rsp.result_value !== rsp_head.result_value)
                begin
                    $display("%0t: result_value expected %h got %h", $time,
                             rsp_head.result_value, rsp.result_value);
                    errors++;
                end
                if (rsp.freed_count !== rsp_head.freed_count)
                begin
                    $display("%0t: freed_count expected %0d got %0d", $time,
                             rsp_head.freed_count, rsp.freed_count);
                    errors++;
                end
                if (rsp.status !== rsp_head.status)
                begin
                    $display("%0t: status expected %0d got %0d", $time,
                             rsp_head.status, rsp.status);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, WD_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        lim_cfg     = LIMIT_MAX;
        idle_cycles = 0;
        errors      = 0;
        words_sent  = 0;
        cfg_writes  = 0;
        alloc_ok    = 0;
        full_seen   = 0;
        range_seen  = 0;
        freed_total = 0;
        burst_left  = 0;
        file_tail   = -1;
        for (int i = 0; i < NUM_CLUSTERS; i++)
        begin
            fat_img[i]   = FREE_MARK;
            fat_known[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limit_floor();
        test_small_table();
        test_single_slot();
        test_mid_table();
        test_wide_table();
        test_full_table();
        test_any_limit();

        drain_results();
        repeat (20) @(posedge clk);
        $display("Sent %0d words over %0d limit settings: %0d allocations, %0d table-full",
                 words_sent, cfg_writes, alloc_ok, full_seen);
        $display("results, %0d out-of-range results, %0d clusters freed by chain walks",
                 range_seen, freed_total);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
